// File: rtl/core/lrz_pkg.sv
// Shared types and constants for the line rasterizer with zig-zag LED mapping.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lrz_pkg;

    localparam int MAX_GRID_SIDE_DEF = 64;

    localparam int COORD_W = 6;
    localparam int SIDE_W  = 7;
    localparam int INDEX_W = 12;
    localparam int COLOR_W = 24;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register map, by place in the list (byte address is 4 * place)
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [SIDE_W-1:0] GRID_WIDTH_RST  = 7'd16;
    localparam logic [SIDE_W-1:0] GRID_HEIGHT_RST = 7'd16;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIDE_W-1:0]  side_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [COLOR_W-1:0] color_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new line on the accepting edge
        logic step;   // emit the current point and advance
    } lrz_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic at_end; // current point is the final one of the line
    } lrz_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/lrz_ctrl.sv
// Controller for the line rasterizer: idle/run sequencing and output beat valid.
// Depends on lrz_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lrz_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 line_valid,
    output logic                line_stall,
    output logic                point_valid,
    input  wire                 point_stall,
    output lrz_pkg::lrz_cmd_t   cmd,
    input  wire lrz_pkg::lrz_stat_t stat
);
    import lrz_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // The output register can take a point when empty or being drained
    assign slot_free   = !out_valid_reg || !point_stall;
    assign line_stall  = (state_reg != ST_IDLE);
    assign point_valid = out_valid_reg;

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && point_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (line_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lrz_dp.sv
// Datapath for the line rasterizer: setup, error stepping and zig-zag index.
// Depends on lrz_pkg; driven by lrz_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module lrz_dp #(
    parameter int MAX_GRID_SIDE = lrz_pkg::MAX_GRID_SIDE_DEF
) (
    input  wire                       clk,
    input  wire lrz_pkg::lrz_cmd_t    cmd,
    output lrz_pkg::lrz_stat_t        stat,
    input  wire lrz_pkg::coord_t      start_x,
    input  wire lrz_pkg::coord_t      start_y,
    input  wire lrz_pkg::coord_t      end_x,
    input  wire lrz_pkg::coord_t      end_y,
    input  wire lrz_pkg::color_t      line_color,
    input  wire lrz_pkg::side_t       grid_width,
    input  wire lrz_pkg::side_t       grid_height,
    output lrz_pkg::index_t           led_index,
    output lrz_pkg::color_t           pixel_color,
    output logic                      last_point
);
    import lrz_pkg::*;

    localparam int    ERR_W    = COORD_W + 3;
    localparam int    PROD_W   = 2 * SIDE_W;
    localparam side_t SIDE_MAX = SIDE_W'(MAX_GRID_SIDE);

    // Line state
    coord_t                   maj_reg;
    coord_t                   min_reg;
    coord_t                   maj_end_reg;
    coord_t                   dmaj_reg;
    coord_t                   dmin_reg;
    logic                     dec_reg;
    logic                     steep_reg;
    logic signed [ERR_W-1:0]  err_reg;
    color_t                   color_reg;

    // Output beat
    index_t                   index_reg;
    color_t                   pcolor_reg;
    logic                     last_reg;

    // Setup logic
    coord_t adx;
    coord_t ady;
    logic   steep;
    coord_t a0;
    coord_t b0;
    coord_t a1;
    coord_t b1;
    logic   flip;
    coord_t s_maj0;
    coord_t s_min0;
    coord_t s_maj1;
    coord_t s_min1;

    // Stepping logic
    logic signed [ERR_W-1:0] err_sum;
    logic signed [ERR_W:0]   err_dbl;
    logic                    min_adv;
    logic signed [ERR_W-1:0] err_next;
    coord_t                  min_next;

    // Index logic
    side_t             w_eff;
    side_t             h_eff;
    coord_t            px;
    coord_t            py;
    coord_t            ux;
    coord_t            uy;
    side_t             col_mul;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] idx_full;

    always_comb
    begin
        adx    = (end_x > start_x) ? end_x - start_x : start_x - end_x;
        ady    = (end_y > start_y) ? end_y - start_y : start_y - end_y;
        steep  = ady > adx;
        a0     = steep ? start_y : start_x;
        b0     = steep ? start_x : start_y;
        a1     = steep ? end_y   : end_x;
        b1     = steep ? end_x   : end_y;
        flip   = a0 > a1;
        s_maj0 = flip ? a1 : a0;
        s_min0 = flip ? b1 : b0;
        s_maj1 = flip ? a0 : a1;
        s_min1 = flip ? b0 : b1;
    end

    always_comb
    begin
        err_sum  = err_reg + $signed({3'b000, dmin_reg});
        err_dbl  = {err_sum, 1'b0};
        min_adv  = err_dbl >= $signed({4'b0000, dmaj_reg});
        err_next = min_adv ? err_sum - $signed({3'b000, dmaj_reg}) : err_sum;
        min_next = min_adv ? (dec_reg ? min_reg - 1'b1 : min_reg + 1'b1) : min_reg;
    end

    // Zig-zag index of the current point; out-of-grid coordinates fold to 0
    always_comb
    begin
        w_eff = (grid_width == '0) ? side_t'(1) :
                (grid_width > SIDE_MAX) ? SIDE_MAX : grid_width;
        h_eff = (grid_height == '0) ? side_t'(1) :
                (grid_height > SIDE_MAX) ? SIDE_MAX : grid_height;
        px    = steep_reg ? min_reg : maj_reg;
        py    = steep_reg ? maj_reg : min_reg;
        ux    = ({1'b0, px} >= w_eff) ? '0 : px;
        uy    = ({1'b0, py} >= h_eff) ? '0 : py;
        col_mul  = {1'b0, ux} + {{(SIDE_W-1){1'b0}}, ux[0]};
        prod     = col_mul * h_eff;
        if (ux[0])
        begin
            idx_full = prod - PROD_W'(1) - {{(PROD_W-COORD_W){1'b0}}, uy};
        end
        else
        begin
            idx_full = prod + {{(PROD_W-COORD_W){1'b0}}, uy};
        end
    end

    assign stat.at_end = (maj_reg == maj_end_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            maj_reg     <= s_maj0;
            min_reg     <= s_min0;
            maj_end_reg <= s_maj1;
            dmaj_reg    <= s_maj1 - s_maj0;
            dmin_reg    <= (s_min1 > s_min0) ? s_min1 - s_min0 : s_min0 - s_min1;
            dec_reg     <= !(s_min0 < s_min1);
            steep_reg   <= steep;
            err_reg     <= '0;
            color_reg   <= line_color;
        end
        else if (cmd.step)
        begin
            maj_reg <= maj_reg + 1'b1;
            min_reg <= min_next;
            err_reg <= err_next;
        end

        if (cmd.step)
        begin
            index_reg  <= idx_full[INDEX_W-1:0];
            pcolor_reg <= color_reg;
            last_reg   <= stat.at_end;
        end
    end

    assign led_index   = index_reg;
    assign pixel_color = pcolor_reg;
    assign last_point  = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/line_raster_to_zigzag_grid.sv
// Top level of the Bresenham line rasterizer with column zig-zag LED mapping.
// Depends on lrz_pkg, lrz_ctrl and lrz_dp; holds the APB register file.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   line    | line_valid / line_stall | start_x start_y end_x end_y line_color
//   point   | point_valid/point_stall | led_index pixel_color last_point
//   apb     | psel penable pready     | pwrite paddr pwdata prdata
//
// A line is accepted once and then yields N points (N = 1..64) in turn, as long as
// the point side does not stall. The error stepper in the datapath sets the pace,
// producing one point per cycle whenever the point side does not stall.
// line_stall is high from the accepting edge until the final point has entered
// the output register; a point waiting there does not hold back the next line.
// A stall on the point side freezes the stepper and holds the output beat.
// Reset (rst_n low, asynchronous) idles the controller, empties the output and
// loads both grid sides with 16.
`timescale 1ns / 1ps
`default_nettype none

module line_raster_to_zigzag_grid #(
    parameter int MAX_GRID_SIDE = lrz_pkg::MAX_GRID_SIDE_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // line channel
    input  wire                          line_valid,
    output logic                         line_stall,
    input  wire lrz_pkg::coord_t         start_x,
    input  wire lrz_pkg::coord_t         start_y,
    input  wire lrz_pkg::coord_t         end_x,
    input  wire lrz_pkg::coord_t         end_y,
    input  wire lrz_pkg::color_t         line_color,
    // point channel
    output logic                         point_valid,
    input  wire                          point_stall,
    output lrz_pkg::index_t              led_index,
    output lrz_pkg::color_t              pixel_color,
    output logic                         last_point,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [lrz_pkg::APB_AW-1:0]    paddr,
    input  wire [lrz_pkg::APB_DW-1:0]    pwdata,
    output logic [lrz_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import lrz_pkg::*;

    side_t     grid_width_reg;
    side_t     grid_height_reg;
    logic      reg_wr;
    logic      reg_sel;
    lrz_cmd_t  cmd;
    lrz_stat_t stat;

    // Registers sit at byte 0 (width) and byte 4 (height); decode on bit 2
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else if (reg_wr)
        begin
            if (reg_sel == REG_GRID_WIDTH)
            begin
                grid_width_reg <= pwdata[SIDE_W-1:0];
            end
            else
            begin
                grid_height_reg <= pwdata[SIDE_W-1:0];
            end
        end
    end

    // Readback of the raw register contents
    always_comb
    begin
        case (reg_sel)
            REG_GRID_WIDTH:  prdata = {{(APB_DW-SIDE_W){1'b0}}, grid_width_reg};
            REG_GRID_HEIGHT: prdata = {{(APB_DW-SIDE_W){1'b0}}, grid_height_reg};
            default:         prdata = '0;
        endcase
    end

    // Sequencing: idle until a line beat arrives, then step one point per free slot
    lrz_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Setup, Bresenham error stepping and zig-zag index mapping
    lrz_dp #(
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .led_index   (led_index),
        .pixel_color (pixel_color),
        .last_point  (last_point)
    );

    // A stalled point beat stays offered and holds its payload
    a_point_holds: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=>
            point_valid && $stable({led_index, pixel_color, last_point}))
        else $error("stalled point beat dropped or changed");

    // An accepted line beat always starts a run
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line_stall |=> line_stall)
        else $error("line accepted but controller did not start");

    // A run only begins after a line beat was offered
    a_run_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(line_stall) |-> $past(line_valid))
        else $error("controller left idle without a line beat");

endmodule

`default_nettype wire
